>>> hw/rtl/epsq_pkg.sv
`default_nettype none

package epsq_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int EVENT_W  = 16;
    localparam int HANDLE_W = 8;
    localparam int DATA_W   = 32;

    localparam logic [MODE_W-1:0] MODE_SUBSCRIBE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNSUBSCRIBE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PUBLISH     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PROCESS     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_SUBS  = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/event_publish_subscribe_queue.sv
`default_nettype none

// Publish/subscribe event queue.
// Input channel (s_*): one command per transfer. s_mode selects subscribe,
// unsubscribe, publish or process; s_event_id, s_subscriber and s_payload
// carry the operands. s_ready is high only while the sequencer is idle, so
// the next command is taken the cycle after the last result transfer.
// Result channel (m_*): subscribe, unsubscribe, publish and an empty or
// unsubscribed process give one transfer with m_last set. A process of an
// event with n subscribers gives n deliveries in list order, m_last on the
// final one. m_pending is the queue fill after the command.
// Steps per command: the slot search reads and compares the used slots in
// order until one matches. publish writes the ring; subscribe searches and
// then writes a handle, or rejects a null handle at once. unsubscribe
// searches, then reads and compares the listed handles in order; on a match
// the last handle is read and moved into the matched place. process answers
// an empty queue at once, else reads the queue head, searches, decides, and
// for each delivery reads the handle, loads the output and offers the result.
// A stalled receiver holds the sequencer in its result state with the result
// registers unchanged. Reset (aresetn low, synchronous) empties the queue and
// the event table; the memories are not cleared and need no clearing pass.
module event_publish_subscribe_queue import epsq_pkg::*; #(
    parameter int EVENT_SLOTS    = 8,
    parameter int SUBS_PER_EVENT = 8,
    parameter int QUEUE_DEPTH    = 16,
    localparam int FW            = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [EVENT_W-1:0]   s_event_id,
    input  wire logic [HANDLE_W-1:0]  s_subscriber,
    input  wire logic [DATA_W-1:0]    s_payload,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic                      m_deliver,
    output logic [HANDLE_W-1:0]       m_target,
    output logic [EVENT_W-1:0]        m_out_event,
    output logic [DATA_W-1:0]         m_out_payload,
    output logic                      m_last,
    output logic [FW-1:0]             m_pending
);

    // slot index, slot count, handle count, handle address, queue pointer
    localparam int SIW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int SCW = $clog2(EVENT_SLOTS + 1);
    localparam int CW  = $clog2(SUBS_PER_EVENT + 1);
    localparam int HAW = (EVENT_SLOTS * SUBS_PER_EVENT > 1) ?
                         $clog2(EVENT_SLOTS * SUBS_PER_EVENT) : 1;
    localparam int HND_DEPTH = EVENT_SLOTS * SUBS_PER_EVENT;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'h0001,
        ST_PUB      = 14'h0002,
        ST_FIFO_RD  = 14'h0004,
        ST_FIFO_CAP = 14'h0008,
        ST_SRCH_RD  = 14'h0010,
        ST_SRCH_CMP = 14'h0020,
        ST_DECIDE   = 14'h0040,
        ST_H_RD     = 14'h0080,
        ST_H_CMP    = 14'h0100,
        ST_LAST_RD  = 14'h0200,
        ST_SWAP     = 14'h0400,
        ST_D_RD     = 14'h0800,
        ST_D_LOAD   = 14'h1000,
        ST_RESP     = 14'h2000
    } state_t;

    // memories
    logic [EVENT_W-1:0]  slot_ev_mem  [EVENT_SLOTS];
    logic [CW-1:0]       slot_cnt_mem [EVENT_SLOTS];
    logic [HANDLE_W-1:0] hnd_mem      [HND_DEPTH];
    logic [EVENT_W-1:0]  fifo_ev_mem  [QUEUE_DEPTH];
    logic [DATA_W-1:0]   fifo_pay_mem [QUEUE_DEPTH];

    logic [EVENT_W-1:0]  slot_ev_rdata;
    logic [CW-1:0]       slot_cnt_rdata;
    logic [HANDLE_W-1:0] hnd_rdata;
    logic [EVENT_W-1:0]  fifo_ev_rdata;
    logic [DATA_W-1:0]   fifo_pay_rdata;

    logic                slot_re, slot_we, cnt_we, hnd_re, hnd_we, fifo_re, fifo_we;
    logic [SIW-1:0]      slot_raddr, slot_waddr, cnt_waddr;
    logic [CW-1:0]       cnt_wdata;
    logic [HAW-1:0]      hnd_raddr, hnd_waddr;
    logic [HANDLE_W-1:0] hnd_wdata;

    // control registers
    state_t              state_reg, state_next;
    logic [SCW-1:0]      slots_used_reg, slots_used_next;
    logic [QW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0]       fill_reg, fill_next;

    // working registers
    logic [MODE_W-1:0]   op_reg, op_next;
    logic [EVENT_W-1:0]  key_reg, key_next;
    logic [HANDLE_W-1:0] sub_reg, sub_next;
    logic [DATA_W-1:0]   pay_reg, pay_next;
    logic [SCW-1:0]      idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [SIW-1:0]      slot_reg, slot_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [HAW-1:0]      base_reg, base_next;
    logic [CW-1:0]       i_reg, i_next;

    // result registers
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                deliver_reg, deliver_next;
    logic [HANDLE_W-1:0] target_reg, target_next;
    logic [EVENT_W-1:0]  oev_reg, oev_next;
    logic [DATA_W-1:0]   opay_reg, opay_next;
    logic                last_reg, last_next;

    // simple one-transfer result
    logic                load_simple;
    logic [STATUS_W-1:0] load_status;

    // slot decision helpers
    logic [SIW-1:0]      sel_slot;
    logic [CW-1:0]       sel_cnt;
    logic [HAW-1:0]      base_calc;

    assign sel_slot  = found_reg ? slot_reg : idx_reg[SIW-1:0];
    assign sel_cnt   = found_reg ? cnt_reg : '0;
    assign base_calc = HAW'(sel_slot) * HAW'(SUBS_PER_EVENT);

    always_comb begin
        state_next      = state_reg;
        slots_used_next = slots_used_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        sub_next        = sub_reg;
        pay_next        = pay_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        status_next     = status_reg;
        deliver_next    = deliver_reg;
        target_next     = target_reg;
        oev_next        = oev_reg;
        opay_next       = opay_reg;
        last_next       = last_reg;

        load_simple = 1'b0;
        load_status = STATUS_OK;
        slot_re     = 1'b0;
        slot_we     = 1'b0;
        cnt_we      = 1'b0;
        hnd_re      = 1'b0;
        hnd_we      = 1'b0;
        fifo_re     = 1'b0;
        fifo_we     = 1'b0;
        slot_raddr  = idx_reg[SIW-1:0];
        slot_waddr  = sel_slot;
        cnt_waddr   = sel_slot;
        cnt_wdata   = sel_cnt + CW'(1);
        hnd_raddr   = base_reg + HAW'(i_reg);
        hnd_waddr   = base_calc + HAW'(sel_cnt);
        hnd_wdata   = sub_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_mode;
                    key_next   = s_event_id;
                    sub_next   = s_subscriber;
                    pay_next   = s_payload;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (s_mode)
                        MODE_SUBSCRIBE: begin
                            if (s_subscriber == '0) begin
                                load_simple = 1'b1;
                                load_status = STATUS_REJECTED;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        MODE_UNSUBSCRIBE: state_next = ST_SRCH_RD;
                        MODE_PUBLISH:     state_next = ST_PUB;
                        default: begin
                            if (fill_reg == '0) begin
                                load_simple = 1'b1;
                                load_status = STATUS_EMPTY;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_FIFO_RD;
                            end
                        end
                    endcase
                end
            end
            ST_PUB: begin
                load_simple = 1'b1;
                state_next  = ST_RESP;
                if (fill_reg == FW'(QUEUE_DEPTH)) begin
                    load_status = STATUS_REJECTED;
                end else begin
                    fifo_we     = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QW'(1);
                    fill_next   = fill_reg + FW'(1);
                end
            end
            ST_FIFO_RD: begin
                fifo_re     = 1'b1;
                rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QW'(1);
                fill_next   = fill_reg - FW'(1);
                state_next  = ST_FIFO_CAP;
            end
            ST_FIFO_CAP: begin
                key_next   = fifo_ev_rdata;
                pay_next   = fifo_pay_rdata;
                state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
                if (idx_reg == slots_used_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    slot_re    = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (slot_ev_rdata == key_reg) begin
                    found_next = 1'b1;
                    slot_next  = idx_reg[SIW-1:0];
                    cnt_next   = slot_cnt_rdata;
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + SCW'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_DECIDE: begin
                slot_next = sel_slot;
                base_next = base_calc;
                i_next    = '0;
                case (op_reg)
                    MODE_SUBSCRIBE: begin
                        load_simple = 1'b1;
                        state_next  = ST_RESP;
                        if ((!found_reg && slots_used_reg == SCW'(EVENT_SLOTS)) ||
                            (found_reg && cnt_reg == CW'(SUBS_PER_EVENT))) begin
                            load_status = STATUS_REJECTED;
                        end else begin
                            hnd_we = 1'b1;
                            cnt_we = 1'b1;
                            if (!found_reg) begin
                                slot_we         = 1'b1;
                                slots_used_next = slots_used_reg + SCW'(1);
                            end
                        end
                    end
                    MODE_UNSUBSCRIBE: begin
                        if (!found_reg) begin
                            load_simple = 1'b1;
                            load_status = STATUS_REJECTED;
                            state_next  = ST_RESP;
                        end else begin
                            state_next = ST_H_RD;
                        end
                    end
                    default: begin
                        if (!found_reg || cnt_reg == '0) begin
                            status_next  = STATUS_NO_SUBS;
                            deliver_next = 1'b0;
                            target_next  = '0;
                            oev_next     = key_reg;
                            opay_next    = pay_reg;
                            last_next    = 1'b1;
                            state_next   = ST_RESP;
                        end else begin
                            state_next = ST_D_RD;
                        end
                    end
                endcase
            end
            ST_H_RD: begin
                if (i_reg == cnt_reg) begin
                    load_simple = 1'b1;
                    load_status = STATUS_REJECTED;
                    state_next  = ST_RESP;
                end else begin
                    hnd_re     = 1'b1;
                    state_next = ST_H_CMP;
                end
            end
            ST_H_CMP: begin
                if (hnd_rdata == sub_reg) begin
                    state_next = ST_LAST_RD;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_H_RD;
                end
            end
            ST_LAST_RD: begin
                hnd_re     = 1'b1;
                hnd_raddr  = base_reg + HAW'(cnt_reg - CW'(1));
                state_next = ST_SWAP;
            end
            ST_SWAP: begin
                // last handle moves into the matched place
                hnd_we      = 1'b1;
                hnd_waddr   = base_reg + HAW'(i_reg);
                hnd_wdata   = hnd_rdata;
                cnt_we      = 1'b1;
                cnt_waddr   = slot_reg;
                cnt_wdata   = cnt_reg - CW'(1);
                load_simple = 1'b1;
                state_next  = ST_RESP;
            end
            ST_D_RD: begin
                hnd_re     = 1'b1;
                state_next = ST_D_LOAD;
            end
            ST_D_LOAD: begin
                status_next  = STATUS_OK;
                deliver_next = 1'b1;
                target_next  = hnd_rdata;
                oev_next     = key_reg;
                opay_next    = pay_reg;
                last_next    = ((i_reg + CW'(1)) == cnt_reg);
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    if (deliver_reg && !last_reg) begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_D_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_simple) begin
            status_next  = load_status;
            deliver_next = 1'b0;
            target_next  = '0;
            oev_next     = '0;
            opay_next    = '0;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slots_used_reg <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        sub_reg     <= sub_next;
        pay_reg     <= pay_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        i_reg       <= i_next;
        status_reg  <= status_next;
        deliver_reg <= deliver_next;
        target_reg  <= target_next;
        oev_reg     <= oev_next;
        opay_reg    <= opay_next;
        last_reg    <= last_next;
    end

    // event table
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_ev_mem[slot_waddr] <= key_reg;
        end
        if (cnt_we) begin
            slot_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (slot_re) begin
            slot_ev_rdata  <= slot_ev_mem[slot_raddr];
            slot_cnt_rdata <= slot_cnt_mem[slot_raddr];
        end
    end

    // subscriber handle lists
    always_ff @(posedge aclk) begin
        if (hnd_we) begin
            hnd_mem[hnd_waddr] <= hnd_wdata;
        end
        if (hnd_re) begin
            hnd_rdata <= hnd_mem[hnd_raddr];
        end
    end

    // message ring
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_ev_mem[wr_ptr_reg]  <= key_reg;
            fifo_pay_mem[wr_ptr_reg] <= pay_reg;
        end
        if (fifo_re) begin
            fifo_ev_rdata  <= fifo_ev_mem[rd_ptr_reg];
            fifo_pay_rdata <= fifo_pay_mem[rd_ptr_reg];
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_RESP);
    assign m_status      = status_reg;
    assign m_deliver     = deliver_reg;
    assign m_target      = target_reg;
    assign m_out_event   = oev_reg;
    assign m_out_payload = opay_reg;
    assign m_last        = last_reg;
    assign m_pending     = fill_reg;

endmodule

`default_nettype wire

>>> hw/rtl/epsq_checker.sv
`default_nettype none

module epsq_checker import epsq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    localparam int FW         = $clog2(QUEUE_DEPTH + 1)
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic                m_deliver,
    input wire logic                m_last,
    input wire logic [FW-1:0]       m_pending
);

    // one command in flight: no new command while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // a result holds until it is taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    // deliveries always carry ok status
    a_deliver_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_deliver |-> m_status == STATUS_OK)
        else $error("delivery with non-ok status");

    // every non-delivery result is the only result of its command
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_deliver |-> m_last)
        else $error("non-delivery result without last");

    // queue fill bounded by depth
    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pending <= FW'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");

endmodule

bind event_publish_subscribe_queue epsq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_epsq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_deliver (m_deliver),
    .m_last    (m_last),
    .m_pending (m_pending)
);

`default_nettype wire
